FILE: design/chsh_pkg.sv
// Shared types and constants for the chained scatter hash table.
`default_nettype none
package chsh_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int CNT_BITS   = SLOT_BITS + 1;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int HASH_BITS  = 32;
  localparam int SIZE_BITS  = 4;

  typedef enum logic [1:0] {
    TAG_EMPTY  = 2'd0,
    TAG_MASTER = 2'd1,
    TAG_SLAVE  = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_ERASE  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_FIRST,
    S_SRCH,
    S_SCAN,
    S_INS_WR2,
    S_FP,
    S_FIN,
    S_NX_CHK,
    S_NX_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    tag_t                  tag;
    logic                  link_ok;
    logic [SLOT_BITS-1:0]  link;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [HASH_BITS-1:0]  hash;
  } slot_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] addr;
    slot_t                data;
  } mem_wr_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_BITS-1:0]  where_slot;
    logic [VALUE_BITS-1:0] found_value;
  } res_t;

endpackage
`default_nettype wire

FILE: design/chsh_slot_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module chsh_slot_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/chsh_seq.sv
// Operation sequencer: clearing pass, insert scan, chain walks and slot rewrites.
`default_nettype none
module chsh_seq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [chsh_pkg::SIZE_BITS-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire chsh_pkg::func_t                 in_func,
  input  wire logic [chsh_pkg::KEY_BITS-1:0]   in_key,
  input  wire logic [chsh_pkg::VALUE_BITS-1:0] in_value,
  input  wire logic [chsh_pkg::HASH_BITS-1:0]  in_hash,
  input  wire logic [chsh_pkg::SLOT_BITS-1:0]  in_slot,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output chsh_pkg::res_t                       res,
  output logic [chsh_pkg::SLOT_BITS-1:0]       raddr,
  input  wire chsh_pkg::slot_t                 rdata,
  output chsh_pkg::mem_wr_t                    mw
);

  localparam int SB = chsh_pkg::SLOT_BITS;
  localparam int CB = chsh_pkg::CNT_BITS;

  chsh_pkg::state_t                  state, state_next;
  logic [chsh_pkg::SIZE_BITS-1:0]    size_log, size_log_next;
  logic [CB-1:0]                     fst, fst_next;
  logic [SB-1:0]                     ptr, ptr_next;
  logic [CB-1:0]                     steps, steps_next;
  logic [SB-1:0]                     home, home_next;
  logic [SB-1:0]                     clr_addr, clr_addr_next;
  chsh_pkg::func_t                   op, op_next;
  logic [chsh_pkg::KEY_BITS-1:0]     key, key_next;
  logic [chsh_pkg::VALUE_BITS-1:0]   val, val_next;
  logic [chsh_pkg::HASH_BITS-1:0]    hash, hash_next;
  chsh_pkg::slot_t                   cur, cur_next;
  chsh_pkg::slot_t                   aux, aux_next;
  logic [SB-1:0]                     fp_link, fp_link_next;
  logic                              fp_ok, fp_ok_next;
  chsh_pkg::res_t                    res_next;

  logic [SB-1:0]                     sl_eff;
  logic [CB-1:0]                     n;
  logic [SB-1:0]                     mask;
  logic [CB-1:0]                     tstart;
  chsh_pkg::slot_t                   new_master;

  function automatic chsh_pkg::slot_t emptied(chsh_pkg::slot_t e);
    chsh_pkg::slot_t r;
    r         = e;
    r.tag     = chsh_pkg::TAG_EMPTY;
    r.link_ok = 1'b0;
    r.link    = '0;
    return r;
  endfunction

  function automatic logic [CB-1:0] raised(logic [CB-1:0] top, logic [SB-1:0] idx);
    logic [CB-1:0] r;
    r = top;
    if (top <= {1'b0, idx}) begin
      r = {1'b0, idx} + CB'(1);
    end
    return r;
  endfunction

  always_comb begin
    if (size_log == '0) begin
      sl_eff = SB'(1);
    end else if (SB'(size_log) > SB'(SB)) begin
      sl_eff = SB'(SB);
    end else begin
      sl_eff = SB'(size_log);
    end
    n      = CB'(1) << sl_eff;
    mask   = SB'(n - CB'(1));
    tstart = (fst < n) ? fst : n;
    new_master.tag     = chsh_pkg::TAG_MASTER;
    new_master.link_ok = 1'b0;
    new_master.link    = '0;
    new_master.key     = key;
    new_master.value   = val;
    new_master.hash    = hash;
  end

  assign raddr = ptr_next;

  always_comb begin
    state_next    = state;
    size_log_next = size_log;
    fst_next      = fst;
    ptr_next      = ptr;
    steps_next    = steps;
    home_next     = home;
    clr_addr_next = clr_addr;
    op_next       = op;
    key_next      = key;
    val_next      = val;
    hash_next     = hash;
    cur_next      = cur;
    aux_next      = aux;
    fp_link_next  = fp_link;
    fp_ok_next    = fp_ok;
    res_next      = res;
    mw.we         = 1'b0;
    mw.addr       = home;
    mw.data       = cur;
    in_ready      = 1'b0;
    res_valid     = 1'b0;

    case (state)
      chsh_pkg::S_CLR: begin
        mw.we         = 1'b1;
        mw.addr       = clr_addr;
        mw.data       = '0;
        clr_addr_next = clr_addr + SB'(1);
        if (clr_addr == SB'(chsh_pkg::SLOT_COUNT - 1)) begin
          state_next = chsh_pkg::S_IDLE;
          fst_next   = n;
        end
      end
      chsh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next    = in_func;
          key_next   = in_key;
          val_next   = in_value;
          hash_next  = in_hash;
          steps_next = '0;
          if (in_func == chsh_pkg::FN_ERASE) begin
            home_next = in_slot;
          end else begin
            home_next = in_hash[SB-1:0] & mask;
          end
          ptr_next   = home_next;
          state_next = chsh_pkg::S_FIRST;
        end
      end
      chsh_pkg::S_FIRST: begin
        cur_next   = rdata;
        state_next = chsh_pkg::S_DONE;
        res_next   = '{chsh_pkg::STAT_MISS, '0, '0};
        case (op)
          chsh_pkg::FN_INSERT: begin
            if (rdata.tag == chsh_pkg::TAG_EMPTY) begin
              mw.we    = 1'b1;
              mw.data  = new_master;
              res_next = '{chsh_pkg::STAT_OK, home, '0};
            end else if (tstart == '0) begin
              res_next = '{chsh_pkg::STAT_FULL, '0, '0};
            end else begin
              ptr_next   = SB'(tstart - CB'(1));
              state_next = chsh_pkg::S_SCAN;
            end
          end
          chsh_pkg::FN_SEARCH: begin
            if (rdata.tag == chsh_pkg::TAG_MASTER) begin
              state_next = chsh_pkg::S_SRCH;
            end
          end
          chsh_pkg::FN_ERASE: begin
            res_next = '{chsh_pkg::STAT_MISS, home, '0};
            if ({1'b0, home} < n && rdata.tag != chsh_pkg::TAG_EMPTY) begin
              res_next = '{chsh_pkg::STAT_OK, home, '0};
              if (rdata.tag == chsh_pkg::TAG_MASTER) begin
                if (rdata.link_ok && {1'b0, rdata.link} < n) begin
                  ptr_next   = rdata.link;
                  state_next = chsh_pkg::S_NX_CHK;
                end else begin
                  mw.we    = 1'b1;
                  mw.data  = emptied(rdata);
                  fst_next = raised(fst, home);
                end
              end else begin
                ptr_next     = rdata.hash[SB-1:0] & mask;
                fp_link_next = rdata.link;
                fp_ok_next   = rdata.link_ok;
                state_next   = chsh_pkg::S_FP;
              end
            end
          end
          default: begin
            res_next = '{chsh_pkg::STAT_MISS, '0, '0};
          end
        endcase
      end
      chsh_pkg::S_SRCH: begin
        if (steps == n) begin
          state_next = chsh_pkg::S_DONE;
        end else if (rdata.tag != chsh_pkg::TAG_EMPTY && rdata.key == key) begin
          res_next   = '{chsh_pkg::STAT_OK, ptr, rdata.value};
          state_next = chsh_pkg::S_DONE;
        end else if (!rdata.link_ok || {1'b0, rdata.link} >= n) begin
          state_next = chsh_pkg::S_DONE;
        end else begin
          ptr_next   = rdata.link;
          steps_next = steps + CB'(1);
        end
      end
      chsh_pkg::S_SCAN: begin
        if (rdata.tag == chsh_pkg::TAG_EMPTY) begin
          fst_next        = {1'b0, ptr};
          mw.we           = 1'b1;
          mw.addr         = ptr;
          mw.data         = cur;
          mw.data.tag     = chsh_pkg::TAG_SLAVE;
          if (cur.tag == chsh_pkg::TAG_MASTER) begin
            mw.data.key   = key;
            mw.data.value = val;
            mw.data.hash  = hash;
            res_next      = '{chsh_pkg::STAT_OK, ptr, '0};
            state_next    = chsh_pkg::S_INS_WR2;
          end else begin
            fp_link_next  = ptr;
            fp_ok_next    = 1'b1;
            ptr_next      = cur.hash[SB-1:0] & mask;
            res_next      = '{chsh_pkg::STAT_OK, home, '0};
            state_next    = chsh_pkg::S_FP;
          end
        end else if (ptr == '0) begin
          res_next   = '{chsh_pkg::STAT_FULL, '0, '0};
          state_next = chsh_pkg::S_DONE;
        end else begin
          ptr_next = ptr - SB'(1);
        end
      end
      chsh_pkg::S_INS_WR2: begin
        mw.we           = 1'b1;
        mw.data.link    = ptr;
        mw.data.link_ok = 1'b1;
        state_next      = chsh_pkg::S_DONE;
      end
      chsh_pkg::S_FP: begin
        if (steps == n || !rdata.link_ok) begin
          state_next = chsh_pkg::S_FIN;
        end else if (rdata.link == home) begin
          mw.we           = 1'b1;
          mw.addr         = ptr;
          mw.data         = rdata;
          mw.data.link    = fp_link;
          mw.data.link_ok = fp_ok;
          state_next      = chsh_pkg::S_FIN;
        end else if ({1'b0, rdata.link} >= n) begin
          state_next = chsh_pkg::S_FIN;
        end else begin
          ptr_next   = rdata.link;
          steps_next = steps + CB'(1);
        end
      end
      chsh_pkg::S_FIN: begin
        mw.we    = 1'b1;
        res_next = '{chsh_pkg::STAT_OK, home, '0};
        if (op == chsh_pkg::FN_INSERT) begin
          mw.data = new_master;
        end else begin
          mw.data  = emptied(cur);
          fst_next = raised(fst, home);
        end
        state_next = chsh_pkg::S_DONE;
      end
      chsh_pkg::S_NX_CHK: begin
        aux_next        = rdata;
        mw.we           = 1'b1;
        mw.data         = rdata;
        mw.data.tag     = cur.tag;
        state_next      = chsh_pkg::S_NX_WR;
      end
      chsh_pkg::S_NX_WR: begin
        mw.we      = 1'b1;
        mw.addr    = ptr;
        mw.data    = emptied(aux);
        fst_next   = raised(fst, ptr);
        state_next = chsh_pkg::S_DONE;
      end
      chsh_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = chsh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = chsh_pkg::S_CLR;
      end
    endcase

    if (cfg_we) begin
      size_log_next = cfg_wdata;
      clr_addr_next = '0;
      state_next    = chsh_pkg::S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= chsh_pkg::S_CLR;
      size_log <= chsh_pkg::SIZE_BITS'(10);
      fst      <= '0;
      clr_addr <= '0;
      steps    <= '0;
    end else begin
      state    <= state_next;
      size_log <= size_log_next;
      fst      <= fst_next;
      clr_addr <= clr_addr_next;
      steps    <= steps_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    home    <= home_next;
    op      <= op_next;
    key     <= key_next;
    val     <= val_next;
    hash    <= hash_next;
    cur     <= cur_next;
    aux     <= aux_next;
    fp_link <= fp_link_next;
    fp_ok   <= fp_ok_next;
    res     <= res_next;
  end

endmodule
`default_nettype wire

FILE: design/chained_scatter_hash_table_core.sv
// Top level of the chained scatter hash table with its stream ports.
// An insert into an empty home slot and an erase of an occupied slot without a
// chain to repair are done with a single write to the slot memory. An erase of
// a master with a successor copies the successor into the home slot and then
// empties the successor's slot. A search reads the chain entries in turn from
// the home slot. A colliding insert scans downward for a free slot, and a
// displaced slave is relinked by walking its chain; erasing a slave also walks
// its chain to relink it. Every step of a scan or walk is one read of the slot
// memory. The next item can be taken in the cycle after the result has moved
// into the output register, so it can start while that result is still pending.
// After reset and after every write of size_log, the block clears all 1024
// slots and accepts no item meanwhile.
`default_nettype none
module chained_scatter_hash_table_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // key [31:0], value [63:32], hash [95:64], slot_index [105:96], zeros above.
  input  wire logic [111:0] s_axis_tdata,
  // func [1:0].
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // where_slot [9:0], found_value [41:10], zeros above.
  output logic [47:0]       m_axis_tdata,
  // status [1:0].
  output logic [1:0]        m_axis_tuser
);

  logic                                  res_valid;
  logic                                  res_ready;
  chsh_pkg::res_t                        res;
  chsh_pkg::res_t                        out_res;
  logic [chsh_pkg::SLOT_BITS-1:0]        raddr;
  chsh_pkg::slot_t                       rdata;
  chsh_pkg::mem_wr_t                     mw;

  chsh_slot_ram #(
    .DATA_W($bits(chsh_pkg::slot_t)),
    .ADDR_W(chsh_pkg::SLOT_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (mw.we),
    .waddr(mw.addr),
    .wdata(mw.data),
    .raddr(raddr),
    .rdata(rdata)
  );

  chsh_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_func  (chsh_pkg::func_t'(s_axis_tuser)),
    .in_key   (s_axis_tdata[31:0]),
    .in_value (s_axis_tdata[63:32]),
    .in_hash  (s_axis_tdata[95:64]),
    .in_slot  (s_axis_tdata[105:96]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .raddr    (raddr),
    .rdata    (rdata),
    .mw       (mw)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'b0, out_res.found_value, out_res.where_slot};
  assign m_axis_tuser = out_res.status;

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !res_valid)
    else $error("Sequencer takes an item while a result is pending.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready && !cfg_we |=> res_valid && $stable(res))
    else $error("Pending result changed before it was taken.");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_axis_tready)
    else $error("Item taken while the table is being cleared.");

endmodule
`default_nettype wire
